// ----- design/iucs_pkg.sv -----
// Shared constants, types and the checksum fold function for the IPv4/UDP checksum engine.
package iucs_pkg;

  localparam logic [15:0] WORD_MAX      = 16'hFFFF;
  localparam logic [15:0] IP_CHECK_WORD = 16'd5;
  localparam logic [15:0] ADDR_FIRST    = 16'd6;
  localparam logic [15:0] ADDR_LAST     = 16'd9;
  localparam logic [15:0] UDP_LEN_WORD  = 16'd2;
  localparam logic [15:0] UDP_CHK_WORD  = 16'd3;
  localparam logic [31:0] PROTO_UDP     = 32'd17;
  localparam logic [15:0] HIGH_BYTE     = 16'hFF00;

  typedef struct packed {
    logic [31:0] ip_sum;
    logic [31:0] udp_sum;
    logic        short_packet;
  } sums_t;

  // End-around carry fold of a 32-bit sum, then complement.
  function automatic logic [15:0] fold_complement(input logic [31:0] s);
    logic [16:0] t;
    logic [15:0] t2;
    t  = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    t2 = t[15:0] + {15'd0, t[16]};
    return ~t2;
  endfunction

endpackage

// ----- design/iucs_accum.sv -----
// Input register and per-packet running sums; captures final sums on the last word.
module iucs_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          packet_word,
  input  logic                 last,
  output logic                 sums_valid,
  output iucs_pkg::sums_t      sums,
  input  logic                 sums_take
);
  import iucs_pkg::*;

  logic        s1_valid;
  logic [15:0] word_r;
  logic        last_r;

  logic [15:0] word_index;
  logic [5:0]  header_words;
  logic [31:0] ip_sum;
  logic [31:0] udp_sum;
  logic [15:0] udp_length;

  logic        s1_go;
  logic        s2_free;
  logic [5:0]  hw_eff;
  logic        ip_add;
  logic        addr_word;
  logic        in_udp;
  logic [15:0] u;
  logic        len_word;
  logic [15:0] len_eff;
  logic [15:0] v;
  logic [16:0] twice_u;
  logic [16:0] twice_u1;
  logic [15:0] d;
  logic [19:0] addend;
  logic [31:0] ip_sum_next;
  logic [31:0] udp_sum_next;
  logic [15:0] word_index_next;
  logic [16:0] half_len;
  logic [16:0] need_len;
  logic        short_next;

  assign s2_free  = !sums_valid || sums_take;
  assign s1_go    = s1_valid && (!last_r || s2_free);
  assign in_stall = s1_valid && !s1_go;

  always_comb begin
    hw_eff    = (word_index == 16'd0) ? {1'b0, word_r[11:8], 1'b0} : header_words;
    ip_add    = (word_index < {10'd0, hw_eff}) && (word_index != IP_CHECK_WORD);
    addr_word = (word_index >= ADDR_FIRST) && (word_index <= ADDR_LAST);
    in_udp    = (word_index >= {10'd0, hw_eff});
    u         = word_index - {10'd0, hw_eff};
    len_word  = in_udp && (u == UDP_LEN_WORD);
    len_eff   = len_word ? word_r : udp_length;
    v         = (u == UDP_CHK_WORD) ? 16'd0 : word_r;
    twice_u   = {u, 1'b0};
    twice_u1  = twice_u + 17'd1;
    d         = 16'd0;
    if (in_udp && (u >= UDP_LEN_WORD)) begin
      if (twice_u1 < {1'b0, len_eff}) begin
        d = v;
      end else if (twice_u < {1'b0, len_eff}) begin
        d = v & HIGH_BYTE;
      end
    end
    addend = {4'd0, (addr_word ? word_r : 16'd0)}
           + {4'd0, ((in_udp && (u < UDP_LEN_WORD)) ? word_r : 16'd0)}
           + {4'd0, (len_word ? word_r : 16'd0)}
           + {4'd0, d}
           + (last_r ? PROTO_UDP[19:0] : 20'd0);
    ip_sum_next     = ip_sum + (ip_add ? {16'd0, word_r} : 32'd0);
    udp_sum_next    = udp_sum + {12'd0, addend};
    word_index_next = (word_index == WORD_MAX) ? word_index : word_index + 16'd1;
    half_len        = ({1'b0, len_eff} + 17'd1) >> 1;
    need_len        = {11'd0, hw_eff} + half_len;
    short_next      = ({1'b0, word_index_next} < ({11'd0, hw_eff} + 17'd3)) ||
                      ({1'b0, word_index_next} < need_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= packet_word;
      last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index   <= 16'd0;
      header_words <= 6'd0;
      ip_sum       <= 32'd0;
      udp_sum      <= 32'd0;
      udp_length   <= 16'd0;
    end else if (s1_go) begin
      if (last_r) begin
        word_index   <= 16'd0;
        header_words <= 6'd0;
        ip_sum       <= 32'd0;
        udp_sum      <= 32'd0;
        udp_length   <= 16'd0;
      end else begin
        word_index   <= word_index_next;
        header_words <= hw_eff;
        ip_sum       <= ip_sum_next;
        udp_sum      <= udp_sum_next;
        udp_length   <= len_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums_valid <= 1'b0;
    end else if (s1_go && last_r) begin
      sums_valid <= 1'b1;
    end else if (sums_take) begin
      sums_valid <= 1'b0;
    end
  end

  // udp_sum here already carries the protocol term
  always_ff @(posedge clk) begin
    if (s1_go && last_r) begin
      sums.ip_sum       <= ip_sum_next;
      sums.udp_sum      <= udp_sum_next;
      sums.short_packet <= short_next;
    end
  end

endmodule

// ----- design/iucs_fold.sv -----
// Fold/complement of the final sums into the output register.
module iucs_fold (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sums_valid,
  input  iucs_pkg::sums_t      sums,
  output logic                 sums_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          ip_checksum,
  output logic [15:0]          udp_checksum,
  output logic                 short_packet
);
  import iucs_pkg::*;

  logic out_ready;

  assign out_ready = !out_valid || !out_stall;
  assign sums_take = sums_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sums_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sums_take) begin
      ip_checksum  <= fold_complement(sums.ip_sum);
      udp_checksum <= fold_complement(sums.udp_sum);
      short_packet <= sums.short_packet;
    end
  end

endmodule

// ----- design/ipv4_udp_checksum_engine.sv -----
// Top level of the IPv4 header and UDP checksum engine.
//
// Input channel: packet_word/last with in_valid, in_stall. One 16-bit word per
// transfer, first byte in the upper half; last marks the final word of a packet.
// Output channel: ip_checksum/udp_checksum/short_packet with out_valid, out_stall.
// One result per packet, produced for the transfer that carries last.
// Throughput: one word per cycle while in_stall is low; the running sums take one word
// per clock in the accumulate stage. The last word passes through the input register,
// the sum capture register and the output register before its result is valid.
// Reset (rst, synchronous) empties all stages and clears the running sums.
// When out_stall holds a result, the next packet's words keep flowing into the
// sums; only a second finished packet waits in the capture register, and once that
// is also full in_stall rises for a word marked last.
module ipv4_udp_checksum_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] packet_word,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] ip_checksum,
  output logic [15:0] udp_checksum,
  output logic        short_packet
);
  import iucs_pkg::*;

  logic  sums_valid;
  logic  sums_take;
  sums_t sums;

  iucs_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .packet_word (packet_word),
    .last        (last),
    .sums_valid  (sums_valid),
    .sums        (sums),
    .sums_take   (sums_take)
  );

  iucs_fold u_fold (
    .clk          (clk),
    .rst          (rst),
    .sums_valid   (sums_valid),
    .sums         (sums),
    .sums_take    (sums_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ip_checksum  (ip_checksum),
    .udp_checksum (udp_checksum),
    .short_packet (short_packet)
  );

endmodule

// ----- test/ipv4_udp_checksum_engine_tb.sv -----
// Self-checking testbench for the IPv4 header and UDP checksum engine.
module ipv4_udp_checksum_engine_tb;
  import iucs_pkg::*;

  localparam int RANDOM_WORDS = 1150;
  localparam int MAX_GAP      = 10;
  localparam int MAX_STALL    = 8;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [15:0] word;
    logic        fin;
  } word_xfer_t;

  typedef struct packed {
    logic [15:0] ip;
    logic [15:0] udp;
    logic        shortp;
  } checksum_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum logic [1:0] {PKT_WELL_FORMED, PKT_BROKEN, PKT_NOISE} pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] packet_word = 16'd0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] ip_checksum;
  logic [15:0] udp_checksum;
  logic        short_packet;

  ipv4_udp_checksum_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .packet_word  (packet_word),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ip_checksum  (ip_checksum),
    .udp_checksum (udp_checksum),
    .short_packet (short_packet)
  );

  always #1 clk = ~clk;

  word_xfer_t       pend_q[$];
  checksum_result_t expected_sums_q[$];
  logic [15:0]      pkt[$];
  int unsigned      pkt_count = 0;

  // running copy of the engine state
  int unsigned word_cnt  = 0;
  int unsigned hdr_words = 0;
  int unsigned seg_len   = 0;
  logic [31:0] ip_acc    = 32'd0;
  logic [31:0] udp_acc   = 32'd0;

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned cycle_limit    = 32'hFFFF_FFFF;

  int unsigned burst_left = 0;
  int unsigned idle_left  = 0;
  word_xfer_t  drive_item;

  stall_mode_t      stall_mode = STALL_NONE;
  logic [31:0]      stall_tick = 32'd0;
  int unsigned      stall_run  = 0;
  logic             hold;
  checksum_result_t want_sums;

  function automatic logic [15:0] rand_word();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic logic [15:0] fold_and_invert(input logic [31:0] s);
    logic [31:0] t;
    t = {16'd0, s[31:16]} + {16'd0, s[15:0]};
    t = t + (t >> 16);
    return ~t[15:0];
  endfunction

  // Adds one accepted word to the running sums; the word marked last yields a result.
  task automatic accumulate_word(input logic [15:0] w, input logic fin);
    int unsigned idx;
    int unsigned u;
    int unsigned v;
    idx = word_cnt;
    if (idx == 0) hdr_words = {27'd0, w[11:8], 1'b0};
    if (idx < hdr_words && idx != IP_CHECK_WORD) ip_acc += {16'd0, w};
    if (idx >= ADDR_FIRST && idx <= ADDR_LAST) udp_acc += {16'd0, w};
    if (idx >= hdr_words) begin
      u = idx - hdr_words;
      if (u < UDP_LEN_WORD) begin
        udp_acc += {16'd0, w};
      end else begin
        v = (u == UDP_CHK_WORD) ? 0 : {16'd0, w};
        if (u == UDP_LEN_WORD) begin
          seg_len = {16'd0, w};
          udp_acc += {16'd0, w};   // length also enters the pseudo-header
          v = {16'd0, w};
        end
        if (2 * u + 1 < seg_len) udp_acc += v;
        else if (2 * u < seg_len) udp_acc += v & {16'd0, HIGH_BYTE};
      end
    end
    if (word_cnt < WORD_MAX) word_cnt++;
    if (fin) begin
      expected_sums_q.push_back('{
        ip:     fold_and_invert(ip_acc),
        udp:    fold_and_invert(udp_acc + PROTO_UDP),
        shortp: (word_cnt < hdr_words + UDP_LEN_WORD + 1) ||
                (word_cnt < hdr_words + ((seg_len + 1) >> 1))
      });
      word_cnt  = 0;
      hdr_words = 0;
      seg_len   = 0;
      ip_acc    = 32'd0;
      udp_acc   = 32'd0;
    end
  endtask

  task automatic queue_packet();
    foreach (pkt[i]) pend_q.push_back('{word: pkt[i], fin: (i == pkt.size() - 1)});
    pkt.delete();
    pkt_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) accumulate_word(packet_word, last);
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          drive_item = pend_q.pop_front();
          in_valid    <= 1'b1;
          packet_word <= drive_item.word;
          last        <= drive_item.fin;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(0, 24);
            idle_left  = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, MAX_GAP);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer, stalls in changing modes
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sums_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual ip %h udp %h short %b",
                   $time, ip_checksum, udp_checksum, short_packet);
          mismatch_count++;
        end else begin
          want_sums = expected_sums_q.pop_front();
          check_field("ip_checksum", want_sums.ip, ip_checksum);
          check_field("udp_checksum", want_sums.udp, udp_checksum);
          check_field("short_packet", {15'd0, want_sums.shortp}, {15'd0, short_packet});
        end
      end
      stall_tick++;
      if (stall_tick % 96 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:  hold = 1'b0;
        STALL_LIGHT: hold = ($urandom_range(0, 99) < 25);
        STALL_HEAVY: hold = ($urandom_range(0, 99) < 75);
        default:     hold = (stall_tick[1:0] != 2'd0);
      endcase
      if (stall_run >= MAX_STALL) hold = 1'b0;
      stall_run = hold ? stall_run + 1 : 0;
      out_stall <= hold;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("ipv4_udp_checksum_engine test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          rand_words;
    int          ihl;
    int          payload;
    int          seg_bytes;
    int          n;
    int          pos;
    int          drop;
    int          roll;
    logic [31:0] tmp;
    logic [15:0] hw;
    logic [3:0]  ihl4;
    pkt_kind_t   kind;

    // header length zero: UDP starts at word 0, trailing word past UDP length
    pkt = {16'h4000, 16'hFFFF, 16'h0008, 16'h1234, 16'hABCD};
    queue_packet();
    // lone word, stream ends inside the header
    pkt = {16'hFFFF};
    queue_packet();
    // UDP length below four, odd
    pkt = {16'h4100, 16'h1111, 16'h2222, 16'h3333, 16'h0003, 16'h4444};
    queue_packet();
    // ends before the UDP length word
    pkt = {16'h4100, 16'hAAAA, 16'h5555};
    queue_packet();
    // odd UDP length, final byte padded low
    pkt = {16'h4000, 16'h0000, 16'h0009, 16'hFFFF, 16'h1234};
    queue_packet();
    // short header: word 5 falls in UDP, address words still in pseudo-header
    pkt = {16'h4200, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 16'h090A,
           16'h0010, 16'h8000, 16'hC0A8, 16'h0001, 16'h0A00, 16'h00FE};
    queue_packet();

    rand_words = 0;
    while (rand_words < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      kind = (roll < 70) ? PKT_WELL_FORMED : (roll < 88) ? PKT_BROKEN : PKT_NOISE;
      case (kind)
        PKT_WELL_FORMED: begin
          ihl       = ($urandom_range(0, 99) < 60) ? 5 : $urandom_range(5, 15);
          payload   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24)
                                                   : $urandom_range(25, 120);
          seg_bytes = 8 + payload;
          ihl4      = ihl[3:0];
          hw        = rand_word();
          pkt.push_back({4'h4, ihl4, hw[7:0]});
          tmp = ihl * 4 + seg_bytes;
          pkt.push_back(tmp[15:0]);
          pkt.push_back(rand_word());
          pkt.push_back(rand_word());
          hw = rand_word();
          pkt.push_back({hw[15:8], PROTO_UDP[7:0]});
          // check word, addresses, options
          for (int i = 5; i < 2 * ihl; i++) pkt.push_back(rand_word());
          pkt.push_back(rand_word());
          pkt.push_back(rand_word());
          tmp = seg_bytes;
          pkt.push_back(tmp[15:0]);
          pkt.push_back(rand_word());
          for (int i = 0; i < (payload + 1) / 2; i++) pkt.push_back(rand_word());
          roll = $urandom_range(0, 99);
          if (roll >= 90) begin
            drop = $urandom_range(1, 6);
            while (drop > 0 && pkt.size() > 1) begin
              pkt.delete(pkt.size() - 1);
              drop--;
            end
          end else if (roll >= 80) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) pkt.push_back(rand_word());
          end
        end
        PKT_BROKEN: begin
          ihl  = $urandom_range(0, 15);
          ihl4 = ihl[3:0];
          n    = $urandom_range(1, 40);
          hw   = rand_word();
          pkt.push_back({hw[15:12], ihl4, hw[7:0]});
          for (int i = 1; i < n; i++) pkt.push_back(rand_word());
          pos = 2 * ihl + UDP_LEN_WORD;
          if (pos < n && $urandom_range(0, 1) == 1) begin
            tmp = $urandom_range(0, 2 * n);
            pkt[pos] = tmp[15:0];
          end
        end
        default: begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) pkt.push_back(rand_word());
        end
      endcase
      rand_words += pkt.size();
      queue_packet();
    end

    cycle_limit = 4 * (pend_q.size() * (MAX_GAP + 1) + pkt_count * (MAX_STALL + 4)) + 2000;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_sums_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ipv4_udp_checksum_engine test passed");
    end else begin
      $display("ipv4_udp_checksum_engine test failed");
    end
    $finish;
  end

endmodule
